### hw/rtl/weighted_threshold_trigger_score_unit_macros.svh
// assertion helpers shared by the rtl
`ifndef WEIGHTED_THRESHOLD_TRIGGER_SCORE_UNIT_MACROS_SVH
`define WEIGHTED_THRESHOLD_TRIGGER_SCORE_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define WTTS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define WTTS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/wtts_pkg.sv
package wtts_pkg;

  localparam int COUNT_BITS  = 24;
  localparam int FRAC_BITS   = 12;
  localparam int PCT_BITS    = 24;
  localparam int FACTOR_BITS = 12;
  localparam int BASE_BITS   = 24;
  localparam int THRESH_FRAC = 8;
  localparam int THRESH_BITS = 28;
  localparam int SCORE_BITS  = FRAC_BITS + 2;
  localparam int NUM_CH      = 3;

  localparam int PROD_BITS   = PCT_BITS + FACTOR_BITS;
  localparam int CNTFX_BITS  = COUNT_BITS + THRESH_FRAC;
  localparam int RATIO_BITS  = FRAC_BITS + 1;
  localparam int WPROD_BITS  = FRAC_BITS + RATIO_BITS;
  localparam int WSUM_BITS   = WPROD_BITS + 2;
  localparam int WEIGHT_BITS = NUM_CH * FRAC_BITS;

  // stage map: product, threshold, one stage per quotient bit, weighting, output
  localparam int CHAN_STG    = FRAC_BITS + 2;
  localparam int S_WMUL      = CHAN_STG;
  localparam int S_OUT       = CHAN_STG + 1;
  localparam int NSTG        = CHAN_STG + 2;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = WEIGHT_BITS;

  localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_FACTOR        = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPLIT_FACTOR       = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_INSERTION_FACTOR   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_BASELINE      = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPLIT_BASELINE     = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_INSERTION_BASELINE = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_PACKED_WEIGHTS     = 3'd6;

  localparam logic [FACTOR_BITS-1:0] FACTOR_RST  = FACTOR_BITS'(768);
  localparam logic [BASE_BITS-1:0]   BASE_RST    = BASE_BITS'(256);
  localparam logic [WEIGHT_BITS-1:0] WEIGHTS_RST = WEIGHT_BITS'(64'd22906492245);

  localparam logic [RATIO_BITS-1:0] RATIO_ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [SCORE_BITS-1:0] SCORE_MAX = SCORE_BITS'(NUM_CH * ((1 << FRAC_BITS) - 1));

  typedef logic [CHAN_STG-1:0] chan_en_t;

endpackage

### hw/rtl/wtts_chan.sv
module wtts_chan
  import wtts_pkg::*;
(
  input  logic                   clk,
  input  chan_en_t               en,
  input  logic [COUNT_BITS-1:0]  count,
  input  logic [PCT_BITS-1:0]    pct,
  input  logic [FACTOR_BITS-1:0] factor,
  input  logic [BASE_BITS-1:0]   base,
  output logic                   fired,
  output logic [RATIO_BITS-1:0]  ratio
);

  logic [PROD_BITS-1:0]   mul_nxt;
  logic [THRESH_BITS-1:0] prod_r;
  logic [COUNT_BITS-1:0]  cnt_r;

  logic [THRESH_BITS-1:0] base_eff;
  logic [THRESH_BITS-1:0] thr_nxt;
  logic [CNTFX_BITS-1:0]  cnt_fx;
  logic [CNTFX_BITS-1:0]  thr_ext;

  logic [THRESH_BITS-1:0] rem_r  [FRAC_BITS+1];
  logic [FRAC_BITS-1:0]   quo_r  [FRAC_BITS+1];
  logic [THRESH_BITS-1:0] thr_r  [FRAC_BITS];
  logic                   fire_r [FRAC_BITS+1];
  logic                   sat_r  [FRAC_BITS+1];

  // product in 20.8, always fits without saturation
  assign mul_nxt = PROD_BITS'(pct) * PROD_BITS'(factor);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod_r <= mul_nxt[THRESH_FRAC +: THRESH_BITS];
      cnt_r  <= count;
    end
  end

  assign base_eff = (base == '0) ? THRESH_BITS'(1) : THRESH_BITS'(base);
  assign thr_nxt  = (prod_r > base_eff) ? prod_r : base_eff;
  assign cnt_fx   = {cnt_r, {THRESH_FRAC{1'b0}}};
  assign thr_ext  = CNTFX_BITS'(thr_nxt);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      thr_r[0]  <= thr_nxt;
      fire_r[0] <= cnt_fx > thr_ext;
      sat_r[0]  <= cnt_fx >= thr_ext;
      rem_r[0]  <= (cnt_fx >= thr_ext) ? '0 : THRESH_BITS'(cnt_fx);
      quo_r[0]  <= '0;
    end
  end

  // restoring division, one quotient bit per stage; remainder stays below thr
  for (genvar i = 0; i < FRAC_BITS; i++) begin : g_div
    logic [THRESH_BITS:0]   rem2;
    logic [THRESH_BITS:0]   diff;
    logic                   ge;
    logic [THRESH_BITS-1:0] rem_nxt;

    assign rem2    = {rem_r[i], 1'b0};
    assign diff    = rem2 - {1'b0, thr_r[i]};
    assign ge      = rem2 >= {1'b0, thr_r[i]};
    assign rem_nxt = ge ? diff[THRESH_BITS-1:0] : rem2[THRESH_BITS-1:0];

    always_ff @(posedge clk) begin
      if (en[i+2]) begin
        rem_r[i+1]  <= rem_nxt;
        quo_r[i+1]  <= {quo_r[i][FRAC_BITS-2:0], ge};
        fire_r[i+1] <= fire_r[i];
        sat_r[i+1]  <= sat_r[i];
      end
    end

    if (i < FRAC_BITS - 1) begin : g_thr
      always_ff @(posedge clk) begin
        if (en[i+2]) begin
          thr_r[i+1] <= thr_r[i];
        end
      end
    end
  end

  assign fired = fire_r[FRAC_BITS];
  assign ratio = sat_r[FRAC_BITS] ? RATIO_ONE : {1'b0, quo_r[FRAC_BITS]};

endmodule

### hw/rtl/weighted_threshold_trigger_score_unit.sv
// weighted threshold trigger score unit
//
// input channel (in_valid/in_ready): one window per transfer, three counts and
// their 16.8 percentiles. result channel (out_valid/out_ready): three fire
// flags, their or, and the 2.12 weighted score, one result per input.
// cfg_we/cfg_index/cfg_wdata write the factors, baselines and packed weights;
// write only while no window is in flight.
//
// throughput: one window per cycle while out_ready is high. the stages are:
// factor multiply, threshold select and compare, one restoring-division stage
// per quotient bit (12), weight multiply, and the output register with the
// score sum. each stage has its own valid bit and moves when the next stage
// is free, so a stalled receiver stops only the stages behind full ones and
// empty slots get squeezed out; nothing is dropped or duplicated.
// reset clears all valid bits and loads the register defaults (factor 3.0,
// baseline 1.0, weights 1/3).
`include "weighted_threshold_trigger_score_unit_macros.svh"

module weighted_threshold_trigger_score_unit
  import wtts_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,

  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,

  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [COUNT_BITS-1:0]    in_clip_count,
  input  logic [COUNT_BITS-1:0]    in_split_count,
  input  logic [COUNT_BITS-1:0]    in_insertion_count,
  input  logic [PCT_BITS-1:0]      in_clip_percentile,
  input  logic [PCT_BITS-1:0]      in_split_percentile,
  input  logic [PCT_BITS-1:0]      in_insertion_percentile,

  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_clip_fired,
  output logic                     out_split_fired,
  output logic                     out_insertion_fired,
  output logic                     out_any_fired,
  output logic [SCORE_BITS-1:0]    out_score
);

  logic [FACTOR_BITS-1:0] clip_factor_r, split_factor_r, insertion_factor_r;
  logic [BASE_BITS-1:0]   clip_base_r, split_base_r, insertion_base_r;
  logic [WEIGHT_BITS-1:0] weights_r;

  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] en;

  logic                  fire_c  [NUM_CH];
  logic [RATIO_BITS-1:0] ratio_c [NUM_CH];

  logic [WPROD_BITS-1:0] wprod_r [NUM_CH];
  logic [NUM_CH-1:0]     fire_w_r;
  logic [WSUM_BITS-1:0]  wsum;

  logic                  clip_fired_r, split_fired_r, insertion_fired_r;
  logic [SCORE_BITS-1:0] score_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_factor_r      <= FACTOR_RST;
      split_factor_r     <= FACTOR_RST;
      insertion_factor_r <= FACTOR_RST;
      clip_base_r        <= BASE_RST;
      split_base_r       <= BASE_RST;
      insertion_base_r   <= BASE_RST;
      weights_r          <= WEIGHTS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CLIP_FACTOR:        clip_factor_r      <= cfg_wdata[FACTOR_BITS-1:0];
        REG_SPLIT_FACTOR:       split_factor_r     <= cfg_wdata[FACTOR_BITS-1:0];
        REG_INSERTION_FACTOR:   insertion_factor_r <= cfg_wdata[FACTOR_BITS-1:0];
        REG_CLIP_BASELINE:      clip_base_r        <= cfg_wdata[BASE_BITS-1:0];
        REG_SPLIT_BASELINE:     split_base_r       <= cfg_wdata[BASE_BITS-1:0];
        REG_INSERTION_BASELINE: insertion_base_r   <= cfg_wdata[BASE_BITS-1:0];
        REG_PACKED_WEIGHTS:     weights_r          <= cfg_wdata[WEIGHT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // a stage may load when it is empty or the stage ahead is loading too
  always_comb begin
    en[NSTG-1] = !v_r[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  assign in_ready = en[0];

  wtts_chan u_clip (
    .clk    (clk),
    .en     (en[CHAN_STG-1:0]),
    .count  (in_clip_count),
    .pct    (in_clip_percentile),
    .factor (clip_factor_r),
    .base   (clip_base_r),
    .fired  (fire_c[0]),
    .ratio  (ratio_c[0])
  );

  wtts_chan u_split (
    .clk    (clk),
    .en     (en[CHAN_STG-1:0]),
    .count  (in_split_count),
    .pct    (in_split_percentile),
    .factor (split_factor_r),
    .base   (split_base_r),
    .fired  (fire_c[1]),
    .ratio  (ratio_c[1])
  );

  wtts_chan u_insertion (
    .clk    (clk),
    .en     (en[CHAN_STG-1:0]),
    .count  (in_insertion_count),
    .pct    (in_insertion_percentile),
    .factor (insertion_factor_r),
    .base   (insertion_base_r),
    .fired  (fire_c[2]),
    .ratio  (ratio_c[2])
  );

  always_ff @(posedge clk) begin
    if (en[S_WMUL]) begin
      for (int c = 0; c < NUM_CH; c++) begin
        wprod_r[c]  <= WPROD_BITS'(weights_r[c*FRAC_BITS +: FRAC_BITS])
                       * WPROD_BITS'(ratio_c[c]);
        fire_w_r[c] <= fire_c[c];
      end
    end
  end

  assign wsum = WSUM_BITS'(wprod_r[0]) + WSUM_BITS'(wprod_r[1]) + WSUM_BITS'(wprod_r[2]);

  always_ff @(posedge clk) begin
    if (en[S_OUT]) begin
      clip_fired_r      <= fire_w_r[0];
      split_fired_r     <= fire_w_r[1];
      insertion_fired_r <= fire_w_r[2];
      score_r           <= wsum[FRAC_BITS +: SCORE_BITS];
    end
  end

  assign out_valid           = v_r[S_OUT];
  assign out_clip_fired      = clip_fired_r;
  assign out_split_fired     = split_fired_r;
  assign out_insertion_fired = insertion_fired_r;
  assign out_any_fired       = clip_fired_r | split_fired_r | insertion_fired_r;
  assign out_score           = score_r;

  `WTTS_ASSERT_NXT(a_accept_enters, clk, rst_n, in_valid && in_ready, v_r[0],
    "accepted transfer did not enter the pipeline")
  `WTTS_ASSERT_NXT(a_stall_keeps, clk, rst_n, v_r[1] && !en[1], v_r[1],
    "stalled threshold stage lost its item")
  `WTTS_ASSERT_IMP(a_fire_is_one, clk, rst_n, v_r[CHAN_STG-1],
    (!fire_c[0] || ratio_c[0] == RATIO_ONE) && (!fire_c[1] || ratio_c[1] == RATIO_ONE)
      && (!fire_c[2] || ratio_c[2] == RATIO_ONE),
    "fired channel ratio below one")
  `WTTS_ASSERT_IMP(a_score_range, clk, rst_n, out_valid, out_score <= SCORE_MAX,
    "score above three times max weight")

endmodule
